@@ hw/rtl/frto_pkg.sv @@
// Shared types, constants and glyph ROM for the frame-rate text overlay.
package frto_pkg;

	localparam int RATE_BITS    = 17;
	localparam int FRAME_BITS   = 12;
	localparam int CFG_IDX_BITS = 2;
	localparam int PIX_BITS     = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_RATE   = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam int GLYPH_W     = 8;
	localparam int GLYPH_H     = 12;
	localparam int MARGIN      = 10;
	localparam int GLYPH_H_IDX = 10;
	localparam int GLYPH_Z_IDX = 11;
	localparam int NUM_GLYPHS  = 12;

	localparam logic [PIX_BITS-1:0] WHITE = 16'hFFFF;

	// MSB of each row byte is the leftmost pixel.
	localparam logic [7:0] GLYPH_ROM [0:NUM_GLYPHS-1][0:GLYPH_H-1] = '{
		'{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
		'{8'h3C, 8'h66, 8'h06, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h60, 8'h60, 8'h66, 8'h7E},
		'{8'h3C, 8'h66, 8'h06, 8'h06, 8'h06, 8'h1C, 8'h06, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
		'{8'h0C, 8'h1C, 8'h3C, 8'h6C, 8'h6C, 8'h6C, 8'h7E, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C},
		'{8'h7E, 8'h60, 8'h60, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
		'{8'h3C, 8'h66, 8'h60, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h7E, 8'h06, 8'h06, 8'h0C, 8'h0C, 8'h18, 8'h18, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30},
		'{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
		'{8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66},
		'{8'h00, 8'h00, 8'h7E, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h7E, 8'h00, 8'h00, 8'h00}
	};

endpackage

@@ hw/rtl/frto_bcd_conv.sv @@
// Sequential binary to BCD converter (shift and add-3), one bit per cycle.
module frto_bcd_conv #(
	parameter int DIGITS = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [frto_pkg::RATE_BITS-1:0]  value,
	output logic                            busy,
	output logic [4*DIGITS-1:0]             bcd
);
	import frto_pkg::*;

	localparam int CNT_BITS = $clog2(RATE_BITS + 1);

	logic [CNT_BITS-1:0]  cnt_q;
	logic [RATE_BITS-1:0] bin_q;
	logic [4*DIGITS-1:0]  bcd_q;
	logic [4*DIGITS-1:0]  adj;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			bin_q <= '0;
			bcd_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(RATE_BITS);
			bin_q <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			bin_q <= {bin_q[RATE_BITS-2:0], 1'b0};
			bcd_q <= {adj[4*DIGITS-2:0], bin_q[RATE_BITS-1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;

endmodule

@@ hw/rtl/frame_rate_text_overlay_core.sv @@
// Top level of the frame-rate text overlay: registers, pixel pipeline and output.
// Draws "<rate>Hz" in white with an 8x12 font, 10 pixels in from the right edge and
// 10 pixels down from the top of an RGB565 stream. One pixel per clock while the output
// is not stalled and no conversion is running, through the input register, placement
// compare, glyph lookup and output register. A write to frame_rate starts a binary to
// decimal conversion; cfg_ready and in_ready are low until it completes. Width and
// height writes need no conversion and do not lower cfg_ready.
module frame_rate_text_overlay_core #(
	parameter int COORD_BITS  = 12,
	parameter int RATE_DIGITS = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [frto_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [frto_pkg::RATE_BITS-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [COORD_BITS-1:0]               pixel_col,
	input  logic [COORD_BITS-1:0]               pixel_row,
	input  logic [frto_pkg::PIX_BITS-1:0]       pixel_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [frto_pkg::PIX_BITS-1:0]       pixel_out
);
	import frto_pkg::*;

	localparam int SIZE_BITS = (COORD_BITS < FRAME_BITS) ? COORD_BITS : FRAME_BITS;
	localparam logic [RATE_BITS-1:0] RATE_TOP = RATE_BITS'(10 ** RATE_DIGITS - 1);

	// config registers
	logic [COORD_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] height_q;
	logic                  cfg_xfer;
	logic                  rate_wr;
	logic [RATE_BITS-1:0]  rate_sat;
	logic                  conv_busy;
	logic [4*RATE_DIGITS-1:0] bcd;

	assign cfg_ready = !conv_busy;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign rate_wr   = cfg_xfer && (cfg_index == REG_FRAME_RATE);
	assign rate_sat  = (cfg_data > RATE_TOP) ? RATE_TOP : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= COORD_BITS'(320);
			height_q <= COORD_BITS'(240);
		end else if (cfg_xfer) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= COORD_BITS'(cfg_data[SIZE_BITS-1:0]);
				REG_FRAME_HEIGHT: height_q <= COORD_BITS'(cfg_data[SIZE_BITS-1:0]);
				default: ;
			endcase
		end
	end

	frto_bcd_conv #(
		.DIGITS (RATE_DIGITS)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rate_wr),
		.value  (rate_sat),
		.busy   (conv_busy),
		.bcd    (bcd)
	);

	// label geometry, registered from config
	logic [2:0]            nd;
	logic [COORD_BITS-1:0] label_w;
	logic [2:0]            nd_q;
	logic [COORD_BITS-1:0] label_w_q;
	logic [COORD_BITS-1:0] x0_q;
	logic                  fits_q;

	always_comb begin
		nd = 3'd1;
		for (int i = 1; i < RATE_DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0)
				nd = 3'(i + 1);
		end
		label_w = COORD_BITS'({nd + 3'd2, 3'b000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q      <= 3'd1;
			label_w_q <= COORD_BITS'(3 * GLYPH_W);
			x0_q      <= '0;
			fits_q    <= 1'b0;
		end else begin
			nd_q      <= nd;
			label_w_q <= label_w;
			x0_q      <= width_q - label_w - COORD_BITS'(MARGIN);
			fits_q    <= (width_q >= label_w + COORD_BITS'(MARGIN));
		end
	end

	// pixel pipeline
	logic                  en;
	logic                  in_xfer;
	logic                  v_s1, v_s2, v_s3;
	logic [COORD_BITS-1:0] col_s1, row_s1;
	logic [PIX_BITS-1:0]   pix_s1, pix_s2, pixel_out_s3;
	logic                  hit_s2;
	logic [5:0]            off_s2;
	logic [3:0]            rowi_s2;

	assign en       = !v_s3 || out_ready;
	assign in_ready = en && !conv_busy;
	assign in_xfer  = in_valid && in_ready;

	// stage 2 placement
	logic [COORD_BITS-1:0] off_full;
	logic [COORD_BITS-1:0] rowi_full;
	logic                  hit_x, hit_y;

	always_comb begin
		off_full  = col_s1 - x0_q;
		rowi_full = row_s1 - COORD_BITS'(MARGIN);
		hit_x = fits_q && (col_s1 >= x0_q) && (off_full < label_w_q) && (col_s1 < width_q);
		hit_y = (row_s1 >= COORD_BITS'(MARGIN)) &&
			(row_s1 < COORD_BITS'(MARGIN + GLYPH_H)) && (row_s1 < height_q);
	end

	// stage 3 glyph lookup
	logic [2:0] pos;
	logic [2:0] bitp;
	logic [2:0] didx;
	logic [3:0] digit;
	logic [3:0] gsel;
	logic [7:0] row_byte;
	logic       set;

	always_comb begin
		pos   = off_s2[5:3];
		bitp  = off_s2[2:0];
		didx  = nd_q - 3'd1 - pos;
		digit = 4'd0;
		for (int i = 0; i < RATE_DIGITS; i++) begin
			if (didx == 3'(i))
				digit = bcd[4*i +: 4];
		end
		if (pos < nd_q)
			gsel = digit;
		else if (pos == nd_q)
			gsel = 4'(GLYPH_H_IDX);
		else
			gsel = 4'(GLYPH_Z_IDX);
		row_byte = GLYPH_ROM[gsel][rowi_s2];
		set      = hit_s2 && row_byte[3'd7 - bitp];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1       <= pixel_col;
			row_s1       <= pixel_row;
			pix_s1       <= pixel_in;
			hit_s2       <= hit_x && hit_y;
			off_s2       <= off_full[5:0];
			rowi_s2      <= hit_y ? rowi_full[3:0] : 4'd0;
			pix_s2       <= pix_s1;
			pixel_out_s3 <= set ? WHITE : pix_s2;
		end
	end

	assign out_valid = v_s3;
	assign pixel_out = pixel_out_s3;

	a_rate_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		rate_wr |=> conv_busy)
		else $error("rate write did not start conversion");

	a_no_pixel_while_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_busy |-> !in_ready)
		else $error("pixel accepted during conversion");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_ready |=> v_s3 && $stable(pixel_out_s3))
		else $error("stalled output changed");

	a_xfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> v_s1)
		else $error("transfer lost at stage 1");

endmodule
